FILE: design/gntm_pkg.sv
// Package with the shared types, sizes and codes of the greedy nearest track matcher.
`timescale 1ns / 1ps
package gntm_pkg;

  localparam int TRACK_SLOTS = 8;
  localparam int FRAME_DETS  = 16;
  localparam int PATH_DEPTH  = 16;

  localparam int SLOT_W  = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int PIDX_W  = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int PCNT_W  = $clog2(PATH_DEPTH + 1);
  localparam int FIDX_W  = (FRAME_DETS > 1) ? $clog2(FRAME_DETS) : 1;
  localparam int FCNT_W  = $clog2(FRAME_DETS + 1);
  localparam int PADDR_W = ((TRACK_SLOTS * PATH_DEPTH) > 1) ?
                           $clog2(TRACK_SLOTS * PATH_DEPTH) : 1;
  localparam int PATH_MEM_DEPTH = TRACK_SLOTS * PATH_DEPTH;
  localparam int DEAD_W  = $clog2(TRACK_SLOTS + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_MATCH_DIST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ABSENT_LIMIT   = 1'd1;

  localparam logic ACT_DETECTION = 1'b0;
  localparam logic ACT_END_FRAME = 1'b1;

  localparam logic KIND_RETIRED = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic       action;
    logic [9:0] det_row;
    logic [9:0] det_col;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] track_id;
    logic [9:0]  final_row;
    logic [9:0]  final_col;
    logic [9:0]  oldest_row;
    logic [9:0]  oldest_col;
    logic [4:0]  path_length;
    logic [3:0]  dead_count;
    logic        last;
  } out_item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic       valid;
    logic       is_eof;
    logic [9:0] row;
    logic [9:0] col;
  } front_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DET_DONE,
    ST_NEW_RD,
    ST_NEW_WR,
    ST_AGE,
    ST_RET_CHK,
    ST_RET_OUT,
    ST_SUM
  } state_e;

  function automatic logic [PADDR_W-1:0] path_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [PIDX_W-1:0] idx);
    path_addr = PADDR_W'(slot) * PADDR_W'(PATH_DEPTH) + PADDR_W'(idx);
  endfunction

  function automatic logic [PIDX_W-1:0] head_inc(input logic [PIDX_W-1:0] head);
    if (head == PIDX_W'(PATH_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head + PIDX_W'(1);
    end
  endfunction

endpackage

FILE: design/greedy_nearest_track_matcher_top.sv
// Top level of the greedy nearest track matcher.
//
//   channel  direction  handshake                    payload
//   in       input      in_valid_i / in_stall_o      in_data_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i    out_data_o (out_item_t)
//   cfg      input      cfg_we_i                     cfg_idx_i, cfg_data_i
//
// A detection holds the back end while every slot is scanned, one slot per cycle.
// An end-of-frame transaction reads and opens a track for each pending detection, ages the
// unclaimed tracks, checks every slot and emits a record per retired track, then the summary;
// output stalls hold the retire and summary steps.
// Reset is asynchronous and active low; no clearing pass is needed.
// A two-entry input queue takes transactions while the back end is busy, until it is full.
`timescale 1ns / 1ps
module greedy_nearest_track_matcher_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  gntm_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output gntm_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [gntm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gntm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gntm_pkg::*;

  front_t front;
  logic   pop;

  gntm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .pop_i      (pop),
    .front_o    (front)
  );

  gntm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .front_i     (front),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/gntm_front.sv
// Input side: a two-entry queue that takes transactions and tags end-of-frame items.
`timescale 1ns / 1ps
module gntm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gntm_pkg::in_item_t in_data_i,
  input  logic              pop_i,
  output gntm_pkg::front_t  front_o
);
  import gntm_pkg::*;

  in_item_t   entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_comb begin
    front_o.valid  = (cnt_q != 2'd0);
    front_o.is_eof = (entry_q[rd_ptr_q].action == ACT_END_FRAME);
    front_o.row    = entry_q[rd_ptr_q].det_row;
    front_o.col    = entry_q[rd_ptr_q].det_col;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with split pointers");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("full queue with split pointers");

endmodule

FILE: design/gntm_back.sv
// Back end: slot table, trajectory and pending memories, sequencer and result register.
`timescale 1ns / 1ps
module gntm_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gntm_pkg::front_t                    front_i,
  output logic                                pop_o,
  input  logic                                cfg_we_i,
  input  logic [gntm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gntm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output gntm_pkg::out_item_t                 out_data_o
);
  import gntm_pkg::*;

  // Configuration.
  logic [9:0] max_dist_q;
  logic [7:0] absent_limit_q;

  // Slot table.
  logic [TRACK_SLOTS-1:0] active_q, claimed_q;
  logic [15:0]       id_q     [TRACK_SLOTS];
  logic [9:0]        row_q    [TRACK_SLOTS];
  logic [9:0]        col_q    [TRACK_SLOTS];
  logic [7:0]        absent_q [TRACK_SLOTS];
  logic [PIDX_W-1:0] head_q   [TRACK_SLOTS];
  logic [PCNT_W-1:0] pcount_q [TRACK_SLOTS];

  // Memories.
  logic [19:0] path_mem [PATH_MEM_DEPTH];
  logic [19:0] pend_mem [FRAME_DETS];
  logic [19:0] path_rd_q, pend_rd_q;

  // Sequencer.
  state_e            state_q, state_d;
  logic [SLOT_W-1:0] s_q, best_s_q;
  logic [20:0]       best_q;
  logic              found_q;
  logic [9:0]        det_row_q, det_col_q;
  logic [FCNT_W-1:0] fcnt_q, pcnt_q, i_q;
  logic [15:0]       next_id_q;
  logic [DEAD_W-1:0] dead_q;

  logic      out_valid_q;
  out_item_t out_q, out_d;

  // Datapath terms.
  logic [9:0]  dr, dc;
  logic [20:0] sq_dist;
  logic        better, s_last, retire, out_free, any_free;
  logic [SLOT_W-1:0] free_s, tp_slot;
  logic [PIDX_W-1:0] oldest_idx;
  logic [PCNT_W:0]   oldest_sum;

  // Control outputs of the sequencer.
  logic tp_en, tp_fresh, pend_we, out_load, det_take;
  logic [9:0] tp_row, tp_col;

  always_comb begin
    dr      = (det_row_q >= row_q[s_q]) ? det_row_q - row_q[s_q] : row_q[s_q] - det_row_q;
    dc      = (det_col_q >= col_q[s_q]) ? det_col_q - col_q[s_q] : col_q[s_q] - det_col_q;
    sq_dist = 21'(dr) * 21'(dr) + 21'(dc) * 21'(dc);
    better  = active_q[s_q] && !claimed_q[s_q] && (sq_dist < best_q);
    s_last  = (s_q == SLOT_W'(TRACK_SLOTS - 1));
    retire  = active_q[s_q] && (absent_q[s_q] >= absent_limit_q);
    out_free = !out_valid_q || !out_stall_i;
  end

  // Lowest inactive slot.
  always_comb begin
    any_free = 1'b0;
    free_s   = '0;
    for (int k = TRACK_SLOTS - 1; k >= 0; k--) begin
      if (!active_q[k]) begin
        any_free = 1'b1;
        free_s   = SLOT_W'(k);
      end
    end
  end

  // Oldest retained point: head minus count, modulo the ring depth.
  always_comb begin
    oldest_sum = (PCNT_W + 1)'(head_q[s_q]) + (PCNT_W + 1)'(PATH_DEPTH)
               - (PCNT_W + 1)'(pcount_q[s_q]);
    if (oldest_sum >= (PCNT_W + 1)'(PATH_DEPTH)) begin
      oldest_idx = PIDX_W'(oldest_sum - (PCNT_W + 1)'(PATH_DEPTH));
    end else begin
      oldest_idx = PIDX_W'(oldest_sum);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (front_i.valid) begin
          if (front_i.is_eof) begin
            state_d = ST_NEW_RD;
          end else if (fcnt_q < FCNT_W'(FRAME_DETS)) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN:     if (s_last) state_d = ST_DET_DONE;
      ST_DET_DONE: state_d = ST_IDLE;
      ST_NEW_RD:   state_d = (i_q < pcnt_q) ? ST_NEW_WR : ST_AGE;
      ST_NEW_WR:   state_d = ST_NEW_RD;
      ST_AGE:      state_d = ST_RET_CHK;
      ST_RET_CHK: begin
        if (retire) begin
          state_d = ST_RET_OUT;
        end else if (s_last) begin
          state_d = ST_SUM;
        end
      end
      ST_RET_OUT:  if (out_free) state_d = s_last ? ST_SUM : ST_RET_CHK;
      ST_SUM:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop_o    = 1'b0;
    det_take = 1'b0;
    tp_en    = 1'b0;
    tp_fresh = 1'b0;
    tp_slot  = best_s_q;
    tp_row   = det_row_q;
    tp_col   = det_col_q;
    pend_we  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pop_o    = front_i.valid;
        det_take = front_i.valid && !front_i.is_eof && (fcnt_q < FCNT_W'(FRAME_DETS));
      end
      ST_DET_DONE: begin
        tp_en   = found_q;
        pend_we = !found_q && (pcnt_q < FCNT_W'(FRAME_DETS));
      end
      ST_NEW_WR: begin
        tp_en    = any_free;
        tp_fresh = 1'b1;
        tp_slot  = free_s;
        tp_row   = pend_rd_q[19:10];
        tp_col   = pend_rd_q[9:0];
      end
      ST_RET_OUT, ST_SUM: out_load = out_free;
      default: ;
    endcase
  end

  // Next result: a retired track record or the frame summary.
  always_comb begin
    out_d = '0;
    if (state_q == ST_RET_OUT) begin
      out_d.kind        = KIND_RETIRED;
      out_d.track_id    = id_q[s_q];
      out_d.final_row   = row_q[s_q];
      out_d.final_col   = col_q[s_q];
      out_d.oldest_row  = path_rd_q[19:10];
      out_d.oldest_col  = path_rd_q[9:0];
      out_d.path_length = 5'(pcount_q[s_q]);
    end else begin
      out_d.kind       = KIND_SUMMARY;
      out_d.dead_count = 4'(dead_q);
      out_d.last       = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tp_en) begin
      path_mem[path_addr(tp_slot, tp_fresh ? '0 : head_q[tp_slot])] <= {tp_row, tp_col};
    end
    if (pend_we) begin
      pend_mem[pcnt_q[FIDX_W-1:0]] <= {det_row_q, det_col_q};
    end
    path_rd_q <= path_mem[path_addr(s_q, oldest_idx)];
    pend_rd_q <= pend_mem[i_q[FIDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      max_dist_q     <= 10'd48;
      absent_limit_q <= 8'd5;
      active_q       <= '0;
      claimed_q      <= '0;
      for (int k = 0; k < TRACK_SLOTS; k++) begin
        id_q[k]     <= '0;
        row_q[k]    <= '0;
        col_q[k]    <= '0;
        absent_q[k] <= '0;
        head_q[k]   <= '0;
        pcount_q[k] <= '0;
      end
      s_q         <= '0;
      best_s_q    <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      det_row_q   <= '0;
      det_col_q   <= '0;
      fcnt_q      <= '0;
      pcnt_q      <= '0;
      i_q         <= '0;
      next_id_q   <= 16'd1;
      dead_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        priority case (cfg_idx_i)
          REG_MAX_MATCH_DIST: max_dist_q     <= cfg_data_i;
          REG_ABSENT_LIMIT:   absent_limit_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (det_take) begin
        det_row_q <= front_i.row;
        det_col_q <= front_i.col;
        best_q    <= 21'(max_dist_q) * 21'(max_dist_q);
        found_q   <= 1'b0;
        s_q       <= '0;
        fcnt_q    <= fcnt_q + FCNT_W'(1);
      end
      if (state_q == ST_IDLE && pop_o && front_i.is_eof) begin
        i_q <= '0;
      end

      if (state_q == ST_SCAN) begin
        if (better) begin
          best_q   <= sq_dist;
          best_s_q <= s_q;
          found_q  <= 1'b1;
        end
        s_q <= s_q + SLOT_W'(1);
      end

      if (pend_we) pcnt_q <= pcnt_q + FCNT_W'(1);

      if (tp_en) begin
        row_q[tp_slot]     <= tp_row;
        col_q[tp_slot]     <= tp_col;
        absent_q[tp_slot]  <= '0;
        claimed_q[tp_slot] <= 1'b1;
        if (tp_fresh) begin
          active_q[tp_slot] <= 1'b1;
          id_q[tp_slot]     <= next_id_q;
          next_id_q         <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
          head_q[tp_slot]   <= head_inc('0);
          pcount_q[tp_slot] <= PCNT_W'(1);
        end else begin
          head_q[tp_slot] <= head_inc(head_q[tp_slot]);
          if (pcount_q[tp_slot] < PCNT_W'(PATH_DEPTH)) begin
            pcount_q[tp_slot] <= pcount_q[tp_slot] + PCNT_W'(1);
          end
        end
      end

      if (state_q == ST_NEW_WR) i_q <= i_q + FCNT_W'(1);

      if (state_q == ST_AGE) begin
        for (int k = 0; k < TRACK_SLOTS; k++) begin
          if (active_q[k] && !claimed_q[k] && absent_q[k] != 8'd255) begin
            absent_q[k] <= absent_q[k] + 8'd1;
          end
        end
        s_q    <= '0;
        dead_q <= '0;
      end

      if (state_q == ST_RET_CHK && !retire) s_q <= s_q + SLOT_W'(1);

      // Result register.
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
        if (state_q == ST_RET_OUT) begin
          active_q[s_q] <= 1'b0;
          absent_q[s_q] <= '0;
          dead_q        <= dead_q + DEAD_W'(1);
          s_q           <= s_q + SLOT_W'(1);
        end else begin
          claimed_q <= '0;
          pcnt_q    <= '0;
          fcnt_q    <= '0;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fcnt_q <= FCNT_W'(FRAME_DETS))
    else $error("frame detection count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pcnt_q <= fcnt_q)
    else $error("more pending detections than detections this frame");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_NEW_WR) |-> ($past(state_q) == ST_NEW_RD))
    else $error("new track opened without a pending read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_RET_OUT) |-> retire)
    else $error("retiring a slot that does not qualify");

endmodule

FILE: dv/gntm_track_checker.sv
// Checker that predicts track matcher results from input transactions and compares them.
`timescale 1ns / 1ps
module gntm_track_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  gntm_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  gntm_pkg::out_item_t out_data_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [9:0]          cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_results_o,
  output int                  retired_seen_o,
  output int                  frames_seen_o
);
  import gntm_pkg::*;

  localparam int NS = TRACK_SLOTS;
  localparam int ND = PATH_DEPTH;

  logic [9:0]  dist_lim;
  logic [7:0]  miss_lim;
  logic        trk_on   [NS];
  logic [15:0] trk_id   [NS];
  logic [9:0]  trk_row  [NS];
  logic [9:0]  trk_col  [NS];
  logic [7:0]  trk_miss [NS];
  logic        trk_hit  [NS];
  logic [19:0] trail    [NS][ND];
  int          trail_hd [NS];
  int          trail_n  [NS];
  logic [19:0] unmatched [$];
  int          dets_in_frame;
  logic [15:0] id_next;
  out_item_t   expected_q [$];

  assign pending_results_o = expected_q.size();

  function automatic void place_point(int s, logic [9:0] r, logic [9:0] c);
    trk_row[s] = r;
    trk_col[s] = c;
    trail[s][trail_hd[s]] = {r, c};
    trail_hd[s] = (trail_hd[s] + 1) % ND;
    if (trail_n[s] < ND) trail_n[s]++;
    trk_miss[s] = '0;
  endfunction

  function automatic void match_detection(logic [9:0] r, logic [9:0] c);
    int unsigned best, d, dr, dc;
    int bs;
    bit hit;
    best = dist_lim * dist_lim;
    bs = 0;
    hit = 0;
    if (dets_in_frame >= FRAME_DETS) return;
    dets_in_frame++;
    for (int s = 0; s < NS; s++) begin
      if (!trk_on[s] || trk_hit[s]) continue;
      dr = (r > trk_row[s]) ? r - trk_row[s] : trk_row[s] - r;
      dc = (c > trk_col[s]) ? c - trk_col[s] : trk_col[s] - c;
      d = dr * dr + dc * dc;
      if (d < best) begin
        best = d;
        bs = s;
        hit = 1;
      end
    end
    if (hit) begin
      place_point(bs, r, c);
      trk_hit[bs] = 1;
    end else if (unmatched.size() < FRAME_DETS) begin
      unmatched.push_back({r, c});
    end
  endfunction

  function automatic void close_frame();
    out_item_t o;
    int idx, dead;
    dead = 0;
    foreach (unmatched[i]) begin
      for (int s = 0; s < NS; s++) begin
        if (trk_on[s]) continue;
        trk_on[s] = 1;
        trk_id[s] = id_next;
        id_next = (id_next == 16'hFFFF) ? 16'd1 : id_next + 16'd1;
        trail_hd[s] = 0;
        trail_n[s] = 0;
        place_point(s, unmatched[i][19:10], unmatched[i][9:0]);
        trk_hit[s] = 1;
        break;
      end
    end
    for (int s = 0; s < NS; s++)
      if (trk_on[s] && !trk_hit[s] && trk_miss[s] != 8'hFF) trk_miss[s]++;
    for (int s = 0; s < NS; s++) begin
      if (!trk_on[s] || trk_miss[s] < miss_lim) continue;
      idx = (trail_hd[s] + ND - (trail_n[s] % (ND + 1))) % ND;
      o = '0;
      o.kind = KIND_RETIRED;
      o.track_id = trk_id[s];
      o.final_row = trk_row[s];
      o.final_col = trk_col[s];
      o.oldest_row = trail[s][idx][19:10];
      o.oldest_col = trail[s][idx][9:0];
      o.path_length = 5'(trail_n[s]);
      expected_q.push_back(o);
      dead++;
      trk_on[s] = 0;
      trk_miss[s] = '0;
    end
    o = '0;
    o.kind = KIND_SUMMARY;
    o.dead_count = 4'(dead);
    o.last = 1'b1;
    expected_q.push_back(o);
    for (int s = 0; s < NS; s++) trk_hit[s] = 0;
    unmatched.delete();
    dets_in_frame = 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      dist_lim = 10'd48;
      miss_lim = 8'd5;
      for (int s = 0; s < NS; s++) begin
        trk_on[s] = 0; trk_id[s] = 0; trk_row[s] = 0; trk_col[s] = 0;
        trk_miss[s] = 0; trk_hit[s] = 0; trail_hd[s] = 0; trail_n[s] = 0;
        for (int k = 0; k < ND; k++) trail[s][k] = '0;
      end
      unmatched.delete();
      expected_q.delete();
      dets_in_frame = 0;
      id_next = 16'd1;
      fail_count_o = 0;
      retired_seen_o = 0;
      frames_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MAX_MATCH_DIST) dist_lim = cfg_data_i;
        else if (cfg_idx_i == REG_ABSENT_LIMIT) miss_lim = cfg_data_i[7:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %p", out_data_i);
        end else begin
          e = expected_q.pop_front();
          if (out_data_i !== e) begin
            fail_count_o++;
            if (fail_count_o <= 10) $display("mismatch: expected %p actual %p", e, out_data_i);
          end
          if (e.kind == KIND_SUMMARY) frames_seen_o++;
          else retired_seen_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.action == ACT_DETECTION) match_detection(in_data_i.det_row, in_data_i.det_col);
        else close_frame();
      end
    end
  end
endmodule

FILE: dv/greedy_nearest_track_matcher_top_tb.sv
// Testbench top that drives frames of detections into the track matcher and gives the verdict.
`timescale 1ns / 1ps
module greedy_nearest_track_matcher_top_tb;
  import gntm_pkg::*;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_we_i;
  in_item_t in_data_i;
  out_item_t out_data_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int fail_count, results_owed, retired_seen, frames_seen;
  int send_idle_pct, recv_idle_pct, hold_cycles, items_sent;
  longint cycle_count;
  logic [9:0] anchor_row [8];
  logic [9:0] anchor_col [8];

  greedy_nearest_track_matcher_top i_dut (.*);

  gntm_track_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_results_o(results_owed),
    .retired_seen_o(retired_seen), .frames_seen_o(frames_seen));

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 1500000) begin
        $display("greedy_nearest_track_matcher_top_tb: FAIL");
        $finish;
      end
    end
  end

  // Receiver stall: random idling, or a long hold when requested.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_item(logic act, logic [9:0] r, logic [9:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{action: act, det_row: r, det_col: c};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [9:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A frame of detections that mostly follow existing tracks with small jitter.
  task automatic random_frame();
    int n;
    logic [9:0] r, c;
    n = ($urandom_range(19) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 9);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(3) != 0) begin
        r = anchor_row[$urandom_range(7)] + 10'($urandom_range(40)) - 10'd20;
        c = anchor_col[$urandom_range(7)] + 10'($urandom_range(40)) - 10'd20;
      end else begin
        r = 10'($urandom);
        c = 10'($urandom);
      end
      send_item(ACT_DETECTION, r, c);
    end
    send_item(ACT_END_FRAME, 10'($urandom), 10'($urandom));
  endtask

  task automatic random_phase(int frames);
    for (int f = 0; f < frames; f++) begin
      if ($urandom_range(5) == 0)
        for (int a = 0; a < 8; a++) begin
          anchor_row[a] = 10'($urandom);
          anchor_col[a] = 10'($urandom);
        end
      random_frame();
    end
  endtask

  initial begin
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    out_stall_i = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent = 0;
    for (int a = 0; a < 8; a++) begin
      anchor_row[a] = 10'($urandom);
      anchor_col[a] = 10'($urandom);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, ties, exact-limit distance, frame overflow.
    write_reg(REG_ABSENT_LIMIT, 8'd2);
    send_item(ACT_DETECTION, 10'd0, 10'd0);
    send_item(ACT_DETECTION, 10'h3FF, 10'h3FF);
    send_item(ACT_DETECTION, 10'd100, 10'd100);
    send_item(ACT_DETECTION, 10'd140, 10'd100);
    send_item(ACT_END_FRAME, 10'h3FF, 10'h3FF);
    send_item(ACT_DETECTION, 10'd120, 10'd100);
    send_item(ACT_DETECTION, 10'd48, 10'd0);
    send_item(ACT_DETECTION, 10'd0, 10'd47);
    send_item(ACT_END_FRAME, 10'd0, 10'd0);
    for (int k = 0; k < 18; k++) send_item(ACT_DETECTION, 10'(k * 57), 10'(1023 - k * 57));
    send_item(ACT_END_FRAME, 10'h2AA, 10'h155);
    send_item(ACT_END_FRAME, 10'h155, 10'h2AA);
    send_item(ACT_END_FRAME, 10'd0, 10'd0);
    drain();

    // Zero limits: nothing matches, every track retires each frame.
    write_reg(REG_MAX_MATCH_DIST, 10'd0);
    write_reg(REG_ABSENT_LIMIT, 8'd0);
    send_idle_pct = 17;
    recv_idle_pct = 73;
    random_phase(8);
    drain();

    write_reg(REG_MAX_MATCH_DIST, 10'h3FF);
    write_reg(REG_ABSENT_LIMIT, 8'd255);
    random_phase(12);
    // Long receiver hold while the sender keeps offering items.
    hold_cycles = 300;
    random_phase(6);
    drain();

    write_reg(REG_MAX_MATCH_DIST, 10'd30);
    write_reg(REG_ABSENT_LIMIT, 8'd1);
    send_idle_pct = 73;
    recv_idle_pct = 17;
    random_phase(15);
    drain();

    write_reg(REG_MAX_MATCH_DIST, 10'd64);
    write_reg(REG_ABSENT_LIMIT, 8'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 410) random_phase(1);
    drain();

    $display("Sent %0d items over %0d frames; %0d retired tracks checked.",
             items_sent, frames_seen, retired_seen);
    if (fail_count == 0) begin
      $display("greedy_nearest_track_matcher_top_tb: PASS");
    end else begin
      $display("greedy_nearest_track_matcher_top_tb: FAIL");
    end
    $finish;
  end
endmodule
